### sv/mrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the median residual codec.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int WordW       = 16;
  localparam int ImgWidthW   = 12;
  localparam int ImgHeightW  = 16;
  localparam int CfgDataW    = 16;
  localparam int CfgIndexW   = 2;

  localparam logic [CfgIndexW-1:0] RegCodecMode   = 2'd0;
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 2'd1;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 2'd2;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [ImgWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [ImgHeightW-1:0] HeightReset = 16'd480;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic frame_end;
  } mrc_flags_t;

endpackage

### sv/med_residual_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// med_residual_codec_top
// Path: an accepted item passes the queue slot, the stage-2 registers and the output register, in that order.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous, clears control state and loads the register defaults.
// The line store is not cleared; each entry is written before it is read.
// Lossless MED predictive coder with zigzag residuals for 16-bit words.
// ----------------------------------------------------------------------------
module med_residual_codec_top import mrc_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WordW-1:0]     in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WordW-1:0]     out_word,
  output logic                 out_frame_end
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int QDataW = WordW + ColW + $bits(mrc_flags_t);

  logic                  codec_mode_r;
  logic [ImgWidthW-1:0]  image_width_r;
  logic [ImgHeightW-1:0] image_height_r;

  logic              q_push, q_full, q_valid, q_pop;
  logic [WordW-1:0]  f_word, b_word;
  logic [ColW-1:0]   f_col, b_col;
  mrc_flags_t        f_flags, b_flags;
  logic [QDataW-1:0] q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r   <= ModeEncode;
      image_width_r  <= WidthReset;
      image_height_r <= HeightReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCodecMode:   codec_mode_r   <= cfg_data[0];
        RegImageWidth:  image_width_r  <= cfg_data[ImgWidthW-1:0];
        RegImageHeight: image_height_r <= cfg_data[ImgHeightW-1:0];
        default: ;
      endcase
    end
  end

  mrc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (ColW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (image_width_r),
    .cfg_height (image_height_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (f_word),
    .q_col      (f_col),
    .q_flags    (f_flags)
  );

  assign q_wr_data = {f_word, f_col, f_flags};
  assign {b_word, b_col, b_flags} = q_rd_data;

  mrc_queue #(
    .DATA_W (QDataW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data)
  );

  mrc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (ColW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .codec_mode    (codec_mode_r),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_word        (b_word),
    .q_col         (b_col),
    .q_flags       (b_flags),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_frame_end (out_frame_end)
  );

endmodule

### sv/mrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_front
// Accepts items, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module mrc_front import mrc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_W     = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ImgWidthW-1:0]  cfg_width,
  input  logic [ImgHeightW-1:0] cfg_height,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WordW-1:0]      in_word,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [WordW-1:0]      q_word,
  output logic [COL_W-1:0]      q_col,
  output mrc_flags_t            q_flags
);

  localparam int CmpW = (COL_W + 1 > ImgWidthW) ? COL_W + 1 : ImgWidthW;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ImgHeightW-1:0] row_r, row_nxt;
  logic [CmpW-1:0]       w_ext, w_eff, col_p1;
  logic [ImgHeightW:0]   h_eff, row_p1;
  logic                  accept, last_col, last_row;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    w_ext = CmpW'(cfg_width);
    if (w_ext == '0) begin
      w_eff = CmpW'(1);
    end else if (w_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff    = (cfg_height == '0) ? (ImgHeightW+1)'(1) : {1'b0, cfg_height};
    col_p1   = CmpW'(col_r) + CmpW'(1);
    row_p1   = {1'b0, row_r} + (ImgHeightW+1)'(1);
    last_col = (col_p1 >= w_eff);
    last_row = (row_p1 >= h_eff);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_p1[ImgHeightW-1:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign q_push            = accept;
  assign q_word            = in_word;
  assign q_col             = col_r;
  assign q_flags.first_row = (row_r == '0);
  assign q_flags.first_col = (col_r == '0);
  assign q_flags.frame_end = last_col && last_row;

endmodule

### sv/mrc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mrc_queue #(
  parameter int DATA_W = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/mrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_back
// Reads the line store, forms the prediction and codes or decodes each item.
// ----------------------------------------------------------------------------
module mrc_back import mrc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_W     = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             codec_mode,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [WordW-1:0] q_word,
  input  logic [COL_W-1:0] q_col,
  input  mrc_flags_t       q_flags,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] out_word,
  output logic             out_frame_end
);

  logic [WordW-1:0] line_mem [MAX_WIDTH];

  logic             s2_valid_r, s2_valid_nxt;
  logic [WordW-1:0] s2_word_r;
  logic [COL_W-1:0] s2_col_r;
  mrc_flags_t       s2_flags_r;
  logic [WordW-1:0] line_rd_r;
  logic             byp_r;
  logic [WordW-1:0] byp_data_r;
  logic [WordW-1:0] left_r, upper_left_r;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_word_r;
  logic             out_frame_end_r;

  logic             fire, load;
  logic [WordW-1:0] up, pred, med, mn, mx, resid, zz, pixel, outv;
  logic [WordW:0]   sum, diff;

  assign fire  = s2_valid_r && (!out_valid_r || !out_stall);
  assign load  = q_valid && (!s2_valid_r || fire);
  assign q_pop = load;

  assign up = byp_r ? byp_data_r : line_rd_r;

  always_comb begin
    mn   = (left_r < up) ? left_r : up;
    mx   = (left_r < up) ? up : left_r;
    sum  = {1'b0, left_r} + {1'b0, up};
    diff = sum - {1'b0, upper_left_r};
    if (sum <= {1'b0, upper_left_r}) begin
      med = mn;
    end else if (diff < {1'b0, mn}) begin
      med = mn;
    end else if (diff > {1'b0, mx}) begin
      med = mx;
    end else begin
      med = diff[WordW-1:0];
    end
    if (s2_flags_r.first_row) begin
      pred = s2_flags_r.first_col ? '0 : left_r;
    end else if (s2_flags_r.first_col) begin
      pred = up;
    end else begin
      pred = med;
    end
  end

  always_comb begin
    if (codec_mode == ModeDecode) begin
      resid = {1'b0, s2_word_r[WordW-1:1]} ^ {WordW{s2_word_r[0]}};
      pixel = pred + resid;
      zz    = '0;
      outv  = pixel;
    end else begin
      pixel = s2_word_r;
      resid = pixel - pred;
      zz    = {resid[WordW-2:0], 1'b0} ^ {WordW{resid[WordW-1]}};
      outv  = zz;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (load) begin
      s2_valid_nxt = 1'b1;
    end else if (fire) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      left_r       <= '0;
      upper_left_r <= '0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        left_r       <= pixel;
        upper_left_r <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      line_mem[s2_col_r] <= pixel;
    end
    if (load) begin
      line_rd_r <= line_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_word_r  <= q_word;
      s2_col_r   <= q_col;
      s2_flags_r <= q_flags;
      byp_r      <= fire && (q_col == s2_col_r);
      byp_data_r <= pixel;
    end
    if (fire) begin
      out_word_r      <= outv;
      out_frame_end_r <= s2_flags_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_frame_end = out_frame_end_r;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the median residual codec. A directed table
// covers the code extremes, geometry edge cases and both modes, then random
// frames with random geometry run under random stalls and one long hold-off
// on the result side. Each accepted item is predicted in the bench and the
// results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mrc_pkg::*;

  localparam int LineDepth   = 2048;
  localparam int RandomItems = 450;
  localparam int CycleLimit  = 200000;
  localparam int PrintLimit  = 50;

  localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

  typedef enum logic [1:0] {RowItem, RowPinned, RowWrite} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CfgIndexW-1:0] index;
    logic [WordW-1:0]     word;
    logic [WordW-1:0]     want_word;
    logic                 want_end;
  } plan_row_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             frame_last;
  } code_word_t;

  localparam int NumDirected = 31;

  localparam plan_row_t DirectedPlan [NumDirected] = '{
    '{RowPinned, RegCodecMode,   16'h0000, 16'h0000, 1'b0},
    '{RowPinned, RegCodecMode,   16'hFFFF, 16'h0001, 1'b0},
    '{RowPinned, RegCodecMode,   16'h7FFF, 16'hFFFF, 1'b0},
    '{RowPinned, RegCodecMode,   16'h8000, 16'h0002, 1'b0},
    '{RowWrite,  RegImageWidth,  16'hF002, 16'h0000, 1'b0},
    '{RowWrite,  RegImageHeight, 16'h0001, 16'h0000, 1'b0},
    '{RowPinned, RegCodecMode,   16'h8000, 16'h0000, 1'b1},
    '{RowWrite,  RegImageHeight, 16'h0000, 16'h0000, 1'b0},
    '{RowPinned, RegCodecMode,   16'h1234, 16'h2468, 1'b0},
    '{RowPinned, RegCodecMode,   16'h1230, 16'h0007, 1'b1},
    '{RowWrite,  RegImageWidth,  16'h0000, 16'h0000, 1'b0},
    '{RowWrite,  RegImageHeight, 16'h0003, 16'h0000, 1'b0},
    '{RowPinned, RegCodecMode,   16'h0100, 16'h0200, 1'b0},
    '{RowPinned, RegCodecMode,   16'h0105, 16'h000A, 1'b0},
    '{RowPinned, RegCodecMode,   16'h00FF, 16'h000B, 1'b1},
    '{RowWrite,  RegUnused,      16'hFFFF, 16'h0000, 1'b0},
    '{RowWrite,  RegImageWidth,  16'h0003, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0010, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0030, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0020, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0018, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0040, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0008, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'hFFFF, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h0000, 16'h0000, 1'b0},
    '{RowItem,   RegCodecMode,   16'h8001, 16'h0000, 1'b0},
    '{RowWrite,  RegCodecMode,   16'hFFFF, 16'h0000, 1'b0},
    '{RowPinned, RegCodecMode,   16'hFFFF, 16'h8000, 1'b0},
    '{RowPinned, RegCodecMode,   16'hFFFE, 16'hFFFF, 1'b0},
    '{RowPinned, RegCodecMode,   16'h0001, 16'hFFFE, 1'b0},
    '{RowPinned, RegCodecMode,   16'h0000, 16'h8000, 1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [WordW-1:0]     in_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [WordW-1:0]     out_word;
  logic                 out_frame_end;

  logic                  mode_q = ModeEncode;
  logic [ImgWidthW-1:0]  width_q = WidthReset;
  logic [ImgHeightW-1:0] height_q = HeightReset;

  logic [WordW-1:0] prev_row [LineDepth];
  logic [WordW-1:0] left_q = '0;
  logic [WordW-1:0] upleft_q = '0;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  code_word_t       pending_codes [$];
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen = 0;

  logic             pin_on = 1'b0;
  logic [WordW-1:0] pin_word = '0;
  logic             pin_last = 1'b0;
  logic [WordW-1:0] last_word = '0;
  bit               in_gaps_on = 1'b1;
  bit               rx_gaps_on = 1'b1;
  int unsigned      hold_left = 0;
  int unsigned      cycles_run = 0;

  med_residual_codec_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_frame_end (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (prev_row[i]) prev_row[i] = '0;
  end

  function automatic int unsigned active_width();
    if (width_q == 0) return 1;
    if (width_q > LineDepth) return LineDepth;
    return width_q;
  endfunction

  function automatic void code_pixel(input logic [WordW-1:0] word_in,
                                     output logic [WordW-1:0] word_out,
                                     output logic frame_last);
    int unsigned      w;
    int unsigned      h;
    int               lo;
    int               hi;
    int               grad;
    logic [WordW-1:0] up;
    logic [WordW-1:0] guess;
    logic [WordW-1:0] resid;
    logic [WordW-1:0] pixel;
    logic             row_done;
    logic             frame_done;
    w = active_width();
    h = (height_q == 0) ? 1 : height_q;
    row_done = (col_pos + 1 >= w);
    frame_done = (row_pos + 1 >= h);
    up = prev_row[col_pos];
    if (row_pos == 0) begin
      guess = (col_pos == 0) ? '0 : left_q;
    end else if (col_pos == 0) begin
      guess = up;
    end else begin
      lo = (left_q < up) ? int'(left_q) : int'(up);
      hi = (left_q < up) ? int'(up) : int'(left_q);
      grad = int'(left_q) + int'(up) - int'(upleft_q);
      if (grad < lo) grad = lo;
      if (grad > hi) grad = hi;
      guess = grad[WordW-1:0];
    end
    if (mode_q == ModeEncode) begin
      pixel = word_in;
      resid = word_in - guess;
      word_out = {resid[WordW-2:0], 1'b0} ^ {WordW{resid[WordW-1]}};
    end else begin
      resid = {1'b0, word_in[WordW-1:1]} ^ {WordW{word_in[0]}};
      pixel = guess + resid;
      word_out = pixel;
    end
    upleft_q = up;
    prev_row[col_pos] = pixel;
    left_q = pixel;
    frame_last = row_done && frame_done;
    if (row_done) begin
      col_pos = 0;
      row_pos = frame_done ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    int unsigned      roll;
    logic [WordW-1:0] v;
    roll = $urandom_range(99);
    if (roll < 25) begin
      v = WordW'($urandom);
    end else if (roll < 40) begin
      case ($urandom_range(3))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = 16'h8000;
        default: v = 16'h7FFF;
      endcase
    end else if (mode_q == ModeDecode) begin
      v = WordW'($urandom_range(0, 24));
    end else begin
      v = last_word + WordW'($urandom_range(0, 16)) - WordW'(8);
    end
    last_word = v;
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WordW-1:0] seen,
                               input logic [WordW-1:0] wanted);
    if (mismatch_count < PrintLimit) begin
      $display("mismatch on %s: got %h, want %h (result %0d)", what, seen, wanted,
               results_seen);
    end
    mismatch_count++;
  endtask

  task automatic push_word(input logic [WordW-1:0] word, input logic pinned,
                           input logic [WordW-1:0] pinned_word, input logic pinned_end);
    while (in_gaps_on && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    pin_on = pinned;
    pin_word = pinned_word;
    pin_last = pinned_end;
    in_valid <= 1'b1;
    in_word <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    case (index)
      RegCodecMode:   mode_q = data[0];
      RegImageWidth:  width_q = data[ImgWidthW-1:0];
      RegImageHeight: height_q = data[ImgHeightW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    code_word_t fresh;
    code_word_t head;
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0) begin
      code_pixel(in_word, fresh.word, fresh.frame_last);
      if (pin_on) begin
        fresh.word = pin_word;
        fresh.frame_last = pin_last;
      end
      pending_codes.insert(pending_codes.size(), fresh);
    end
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_codes.size() == 0) begin
        flag_mismatch("item with nothing pending", out_word, '0);
      end else begin
        head = pending_codes.pop_front();
        if (out_word !== head.word) begin
          flag_mismatch("out_word", out_word, head.word);
        end
        if (out_frame_end !== head.frame_last) begin
          flag_mismatch("out_frame_end", WordW'(out_frame_end), WordW'(head.frame_last));
        end
      end
      results_seen++;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_gaps_on && ($urandom_range(99) < 26);
      end
    end
  end

  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned seg;
    int unsigned span;
    int unsigned roll;
    int unsigned w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegCodecMode;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedPlan[i]) begin
      if (DirectedPlan[i].kind == RowWrite) begin
        write_register(DirectedPlan[i].index, DirectedPlan[i].word);
      end else begin
        push_word(DirectedPlan[i].word, DirectedPlan[i].kind == RowPinned,
                  DirectedPlan[i].want_word, DirectedPlan[i].want_end);
      end
    end

    // A zero height makes the current row the last one, so the frame closes.
    write_register(RegImageHeight, '0);
    while (col_pos != 0 || row_pos != 0) begin
      push_word(pick_word(), 1'b0, '0, 1'b0);
      @(negedge clk);
      in_valid <= 1'b0;
    end

    // A width field above the line store depth starts a one-row frame, and
    // shrinking the width to one closes that row on the next item.
    write_register(RegCodecMode, CfgDataW'($urandom));
    write_register(RegImageWidth, 16'h0FFF);
    write_register(RegImageHeight, 16'h0001);
    repeat (16) push_word(pick_word(), 1'b0, '0, 1'b0);
    write_register(RegImageWidth, 16'h0000);
    push_word(pick_word(), 1'b0, '0, 1'b0);

    sent = 0;
    seg = 0;
    while (sent < RandomItems) begin
      write_register(RegCodecMode, CfgDataW'($urandom));
      if (col_pos == 0 && row_pos == 0) begin
        roll = $urandom_range(9);
        if (roll == 0) begin
          w = 0;
        end else if (roll < 8) begin
          w = $urandom_range(1, 12);
        end else begin
          w = $urandom_range(13, 64);
        end
        write_register(RegImageWidth, {4'($urandom), ImgWidthW'(w)});
        write_register(RegImageHeight, CfgDataW'($urandom_range(0, 6)));
      end else if ($urandom_range(1) == 0) begin
        // Within a frame the width may only shrink, so every column read was
        // written by the row above.
        w = $urandom_range(0, active_width());
        write_register(RegImageWidth, {4'($urandom), ImgWidthW'(w)});
        write_register(RegImageHeight, CfgDataW'($urandom_range(0, 8)));
      end
      if ($urandom_range(4) == 0) write_register(RegUnused, CfgDataW'($urandom));
      span = $urandom_range(10, 60);
      in_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      if (seg == 3) begin
        span = 90;
        in_gaps_on = 1'b0;
      end
      if (seg == 6) begin
        span = 80;
        in_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      for (int k = 0; k < span; k++) begin
        push_word(pick_word(), 1'b0, '0, 1'b0);
        if (seg == 3 && k == 0) hold_left = 150;
      end
      sent += span;
      seg++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
